/* hdl/slfe_pkg.sv */
// ----------------------------------------------------------------------------
// slfe_pkg
// shared types and constants of the sync/length frame extractor
// ----------------------------------------------------------------------------
package slfe_pkg;

   localparam int BYTE_WIDTH        = 8;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int REMAIN_WIDTH      = 17;
   localparam int HEADER_POS_WIDTH  = 3;

   localparam logic [BYTE_WIDTH-1:0] SYNC_FIRST_RESET  = 8'h55;
   localparam logic [BYTE_WIDTH-1:0] SYNC_SECOND_RESET = 8'h66;

   // header is eight bytes, trailer two, so a frame is ten plus length
   localparam logic [HEADER_POS_WIDTH-1:0] HEADER_LAST_POS = 3'd7;
   localparam logic [HEADER_POS_WIDTH-1:0] SECOND_SYNC_POS = 3'd2;
   localparam logic [HEADER_POS_WIDTH-1:0] LEN_LOW_POS     = 3'd3;
   localparam logic [HEADER_POS_WIDTH-1:0] LEN_HIGH_POS    = 3'd4;
   localparam logic [REMAIN_WIDTH-1:0]     TRAILER_BYTES   = 17'd2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_FIRST  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_SECOND = 1'd1;

   // result queue
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data;
      logic                  first;
      logic                  last;
      logic                  run_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } parse_out_type;

   typedef struct packed {
      logic [QUEUE_LEVEL_WIDTH-1:0] level;
      logic                         room;
   } queue_status_type;

endpackage

/* hdl/slfe_parser.sv */
// ----------------------------------------------------------------------------
// slfe_parser
// sync hunt and frame length tracking, up to two results per byte
// ----------------------------------------------------------------------------
module slfe_parser
   import slfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [BYTE_WIDTH-1:0] rx_byte,
   input  logic [BYTE_WIDTH-1:0] sync_first,
   input  logic [BYTE_WIDTH-1:0] sync_second,
   output parse_out_type         parse_out
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_FIRST,
      PH_HEADER,
      PH_BODY
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [HEADER_POS_WIDTH-1:0] pos_ff, pos_in;
   logic [BYTE_WIDTH-1:0]       len_low_ff, len_low_in;
   logic [REMAIN_WIDTH-1:0]     remain_ff, remain_in;
   logic [REMAIN_WIDTH-1:0]     remain_hdr;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      len_low_in = len_low_ff;
      remain_in  = remain_ff;
      remain_hdr = remain_ff;
      parse_out  = '0;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == sync_first) begin
               phase_in = PH_FIRST;
            end
         end
         PH_FIRST: begin
            // second-byte test first, so equal sync bytes commit
            if (rx_byte == sync_second) begin
               parse_out.count = 2'd2;
               parse_out.r0    = '{data: sync_first, first: 1'b1, last: 1'b0,
                                   run_last: 1'b0};
               parse_out.r1    = '{data: rx_byte, first: 1'b0, last: 1'b0,
                                   run_last: 1'b1};
               phase_in = PH_HEADER;
               pos_in   = SECOND_SYNC_POS;
            end else if (rx_byte != sync_first) begin
               phase_in = PH_HUNT;
            end
         end
         PH_HEADER: begin
            parse_out.count = 2'd1;
            parse_out.r0    = '{data: rx_byte, first: 1'b0, last: 1'b0,
                                run_last: 1'b1};
            if (pos_ff == LEN_LOW_POS) begin
               len_low_in = rx_byte;
            end
            if (pos_ff == LEN_HIGH_POS) begin
               remain_hdr = {1'b0, rx_byte, len_low_ff};
            end
            if (pos_ff == HEADER_LAST_POS) begin
               remain_in = remain_hdr + TRAILER_BYTES;
               pos_in    = '0;
               phase_in  = PH_BODY;
            end else begin
               remain_in = remain_hdr;
               pos_in    = pos_ff + 3'd1;
            end
         end
         PH_BODY: begin
            parse_out.count = 2'd1;
            if (remain_ff <= 17'd1) begin
               parse_out.r0 = '{data: rx_byte, first: 1'b0, last: 1'b1,
                                run_last: 1'b1};
               remain_in    = '0;
               phase_in     = PH_HUNT;
            end else begin
               parse_out.r0 = '{data: rx_byte, first: 1'b0, last: 1'b0,
                                run_last: 1'b1};
               remain_in    = remain_ff - 17'd1;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         pos_ff     <= '0;
         len_low_ff <= '0;
         remain_ff  <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         len_low_ff <= len_low_in;
         remain_ff  <= remain_in;
      end
   end

endmodule

/* hdl/slfe_result_queue.sv */
// ----------------------------------------------------------------------------
// slfe_result_queue
// small result register queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module slfe_result_queue
   import slfe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  parse_out_type    parse_out,
   input  logic             pop,
   output result_type       head,
   output logic             not_empty,
   output queue_status_type status
);

   result_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [QUEUE_LEVEL_WIDTH-1:0] level_ff, level_in;
   logic [QUEUE_LEVEL_WIDTH-1:0] push_n;
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_next;

   assign push_n      = push ? QUEUE_LEVEL_WIDTH'(parse_out.count) : '0;
   assign wr_ptr_next = wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
   assign wr_ptr_in   = wr_ptr_ff + QUEUE_PTR_WIDTH'(push_n);
   assign level_in    = level_ff + push_n - QUEUE_LEVEL_WIDTH'(pop);

   assign head          = entry_ff[rd_ptr_ff];
   assign not_empty     = (level_ff != '0);
   assign status.level  = level_ff;
   // room for the two results of a commit
   assign status.room   = (level_ff <= QUEUE_LEVEL_WIDTH'(QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push && (parse_out.count != 2'd0)) begin
         entry_ff[wr_ptr_ff] <= parse_out.r0;
      end
      if (push && (parse_out.count == 2'd2)) begin
         entry_ff[wr_ptr_next] <= parse_out.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         level_ff  <= level_in;
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
      end
   end

endmodule

/* hdl/sync_length_frame_extractor.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_extractor
// two-byte sync hunt and length-field deframer for a received byte stream
// ----------------------------------------------------------------------------
//  channel  ports                    moves
//  req      req_valid/req_ready      one received byte per transaction
//  rsp      rsp_valid/rsp_ready      one frame byte with first/last/run marks
//  csr      csr_wr_en/index/wdata    write of sync_first or sync_second
//
//  one byte is taken per cycle while the queue has room; it is held in the input register,
//  then the parser turns it into 0, 1 or 2 results in the four-entry queue
//  a result appears on rsp in the cycle after parsing at the earliest
//  reset is synchronous and returns the hunt state and default sync bytes
//  the input register waits while the queue has fewer than two free entries
// ----------------------------------------------------------------------------
module sync_length_frame_extractor
   import slfe_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // input byte channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BYTE_WIDTH-1:0]      req_rx_byte,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [BYTE_WIDTH-1:0]      rsp_frame_byte,
   output logic                       rsp_frame_first,
   output logic                       rsp_frame_last,
   output logic                       rsp_run_last,
   // register write port
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [BYTE_WIDTH-1:0]      csr_wdata
);

   // sync registers
   logic [BYTE_WIDTH-1:0] sync_first_ff;
   logic [BYTE_WIDTH-1:0] sync_second_ff;

   // input register
   logic                  in_valid_ff;
   logic [BYTE_WIDTH-1:0] in_byte_ff;

   logic             fire;
   logic             pop;
   parse_out_type    parse_out;
   result_type       head;
   queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // byte moves on to the parser only when the queue can take a commit pair
   assign fire      = in_valid_ff && q_status.room;
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   slfe_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .rx_byte     (in_byte_ff),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .parse_out   (parse_out)
   );

   assign pop = rsp_valid && rsp_ready;

   slfe_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .parse_out (parse_out),
      .pop       (pop),
      .head      (head),
      .not_empty (rsp_valid),
      .status    (q_status)
   );

   assign rsp_frame_byte  = head.data;
   assign rsp_frame_first = head.first;
   assign rsp_frame_last  = head.last;
   assign rsp_run_last    = head.run_last;

   // ---------------------------------------------------------------- checks

   // queue never overfills
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.level <= QUEUE_LEVEL_WIDTH'(QUEUE_DEPTH))
      else $error("result queue level above depth");

   // the held first sync byte is never the end of a byte's run
   a_first_not_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_first |-> !rsp_run_last)
      else $error("first sync result marked as run end");

   // a frame end is always the only result of its byte
   a_last_is_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_run_last && !rsp_frame_first)
      else $error("frame end without run end");

   // nothing is offered right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !in_valid_ff)
      else $error("result pending right after reset");

endmodule

/* test/sync_length_frame_extractor_test.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_extractor_test
// self-checking bench: feeds byte streams with framed and broken sync runs,
// predicts every frame byte with its marks, and checks the result channel
// ----------------------------------------------------------------------------
module sync_length_frame_extractor_test;

   timeunit 1ns;
   timeprecision 1ps;

   import slfe_pkg::*;

   localparam int DRAIN_CYCLES = 12;     // input register, parser, queue, margin
   localparam int QUIET_LIMIT  = 4000;   // cycles with no transaction on any side
   localparam int PHASE_BYTES  = 380;

   typedef enum logic [1:0] {
      HUNT,
      FIRST_SEEN,
      HEADER,
      BODY
   } deframe_state_type;

   // ------------------------------------------------------------------------
   // frame byte predictor and result checker
   // ------------------------------------------------------------------------
   class frame_scoreboard;
      logic [BYTE_WIDTH-1:0]       sync_first;
      logic [BYTE_WIDTH-1:0]       sync_second;
      deframe_state_type           state;
      logic [HEADER_POS_WIDTH-1:0] hdr_pos;
      logic [BYTE_WIDTH-1:0]       len_low;
      logic [REMAIN_WIDTH-1:0]     remaining;
      result_type                  frame_bytes_q[$];
      int                          errors;

      function new();
         sync_first  = SYNC_FIRST_RESET;
         sync_second = SYNC_SECOND_RESET;
         state       = HUNT;
         hdr_pos     = '0;
         len_low     = '0;
         remaining   = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [BYTE_WIDTH-1:0] val);
         case (idx)
            CSR_SYNC_FIRST:  sync_first  = val;
            CSR_SYNC_SECOND: sync_second = val;
            default: ;
         endcase
      endfunction

      function void push_byte(logic [BYTE_WIDTH-1:0] data, logic first, logic last,
                              logic run_last);
         result_type r;
         r.data     = data;
         r.first    = first;
         r.last     = last;
         r.run_last = run_last;
         frame_bytes_q.push_back(r);
      endfunction

      // advance the deframer by one received byte
      function void note_byte(logic [BYTE_WIDTH-1:0] b);
         case (state)
            HUNT: begin
               if (b == sync_first)
                  state = FIRST_SEEN;
            end
            FIRST_SEEN: begin
               // second-byte test wins over the repeat test
               if (b == sync_second) begin
                  push_byte(sync_first, 1'b1, 1'b0, 1'b0);
                  push_byte(b, 1'b0, 1'b0, 1'b1);
                  state   = HEADER;
                  hdr_pos = SECOND_SYNC_POS;
               end else if (b != sync_first) begin
                  state = HUNT;
               end
            end
            HEADER: begin
               if (hdr_pos == LEN_LOW_POS)
                  len_low = b;
               if (hdr_pos == LEN_HIGH_POS)
                  remaining = {1'b0, b, len_low};
               push_byte(b, 1'b0, 1'b0, 1'b1);
               if (hdr_pos == HEADER_LAST_POS) begin
                  remaining = remaining + TRAILER_BYTES;
                  hdr_pos   = '0;
                  state     = BODY;
               end else begin
                  hdr_pos = hdr_pos + 1'b1;
               end
            end
            default: begin
               if (remaining <= 1) begin
                  remaining = '0;
                  push_byte(b, 1'b0, 1'b1, 1'b1);
                  state = HUNT;
               end else begin
                  remaining = remaining - 1'b1;
                  push_byte(b, 1'b0, 1'b0, 1'b1);
               end
            end
         endcase
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (frame_bytes_q.size() == 0) begin
            $error("unexpected result: frame_byte %0h", got.data);
            errors++;
            return;
         end
         want = frame_bytes_q.pop_front();
         if (got.data !== want.data) begin
            $error("frame_byte: expected %0h, actual %0h", want.data, got.data);
            errors++;
         end
         if (got.first !== want.first) begin
            $error("frame_first: expected %0b, actual %0b", want.first, got.first);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("frame_last: expected %0b, actual %0b", want.last, got.last);
            errors++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
            errors++;
         end
      endfunction

      function int pending();
         return frame_bytes_q.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block under test
   // ------------------------------------------------------------------------
   logic                       clock;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic [BYTE_WIDTH-1:0]      req_rx_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic [BYTE_WIDTH-1:0]      rsp_frame_byte;
   logic                       rsp_frame_first;
   logic                       rsp_frame_last;
   logic                       rsp_run_last;
   logic                       csr_wr_en   = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index   = '0;
   logic [BYTE_WIDTH-1:0]      csr_wdata   = '0;

   sync_length_frame_extractor uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_frame_first (rsp_frame_first),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_run_last    (rsp_run_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   frame_scoreboard sb = new();

   int send_gap_pct  = 0;   // chance of a sender gap before a byte
   int rsp_stall_pct = 0;   // chance of rsp_ready low in a cycle
   int bytes_sent    = 0;
   int quiet_cycles  = 0;

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // result side: random back-pressure, check every rsp transaction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result('{data: rsp_frame_byte, first: rsp_frame_first,
                           last: rsp_frame_last, run_last: rsp_run_last});
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog: ends a run that stops moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sync_length_frame_extractor test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------

   // one req transaction, with an optional gap in front of it
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] b);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   // stop sending, let every predicted byte come out, then let hunt bytes settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; the task waits with csr_wr_en low before it returns
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [BYTE_WIDTH-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   // well-formed frame with random content and the given payload length
   task automatic send_frame(input logic [15:0] len);
      send_byte(sb.sync_first);
      if ($urandom_range(9) == 0)
         send_byte(sb.sync_first);   // repeated first sync byte
      send_byte(sb.sync_second);
      send_byte(BYTE_WIDTH'($urandom_range(255)));
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      repeat (3) send_byte(BYTE_WIDTH'($urandom_range(255)));
      repeat (int'(len) + 2) send_byte(BYTE_WIDTH'($urandom_range(255)));
   endtask

   // mostly frames, some broken sync runs, some plain noise
   task automatic send_random_sequence();
      int                    kind;
      int                    pick;
      logic [BYTE_WIDTH-1:0] bad;
      kind = $urandom_range(99);
      if (kind < 75) begin
         pick = $urandom_range(99);
         if (pick < 80)
            send_frame(16'($urandom_range(0, 8)));
         else if (pick < 97)
            send_frame(16'($urandom_range(9, 64)));
         else
            send_frame(16'($urandom_range(65, 400)));
      end else if (kind < 90) begin
         // first sync byte, maybe repeated, then a byte that breaks the pair
         do bad = BYTE_WIDTH'($urandom_range(255));
         while (bad == sb.sync_second || bad == sb.sync_first);
         send_byte(sb.sync_first);
         if ($urandom_range(1) == 1)
            send_byte(sb.sync_first);
         send_byte(bad);
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(BYTE_WIDTH'($urandom_range(255)));
      end
   endtask

   // one setting of sync bytes and idling, drained first and once more halfway through
   task automatic run_phase(input int gap_pct, input int stall_pct,
                            input logic [BYTE_WIDTH-1:0] first_val,
                            input logic [BYTE_WIDTH-1:0] second_val);
      int   start;
      logic paused;
      wait_drained();
      write_csr(CSR_SYNC_FIRST, first_val);
      write_csr(CSR_SYNC_SECOND, second_val);
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      start  = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - start < PHASE_BYTES) begin
         send_random_sequence();
         if (!paused && bytes_sent - start > PHASE_BYTES / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: noise at the byte extremes, repeated first sync byte,
      // then a zero-length frame with all-ones and all-zeros content
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_FIRST_RESET);
      send_byte(SYNC_FIRST_RESET);
      send_byte(SYNC_SECOND_RESET);
      send_byte(8'hFF);
      send_byte(8'h00);             // length low
      send_byte(8'h00);             // length high
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hAA);
      send_byte(8'hFF);             // trailer
      send_byte(8'h00);

      // broken pair: first sync byte followed by something else
      send_byte(SYNC_FIRST_RESET);
      send_byte(8'h12);

      // held first sync byte: rewrite sync_first while waiting for the second,
      // the committed frame must open with the new register value
      send_byte(SYNC_FIRST_RESET);
      wait_drained();
      write_csr(CSR_SYNC_FIRST, 8'h77);
      send_byte(SYNC_SECOND_RESET);
      send_byte(8'h5A);
      send_byte(8'h01);             // one payload byte
      send_byte(8'h00);
      repeat (3) send_byte(BYTE_WIDTH'($urandom_range(255)));
      send_byte(8'hC3);
      send_byte(8'h3C);
      send_byte(8'h96);

      // no idling, default sync bytes, then one frame whose length uses the high byte
      run_phase(0, 0, SYNC_FIRST_RESET, SYNC_SECOND_RESET);
      send_frame(16'h0105);

      run_phase(70, 0, 8'h00, 8'hFF);
      run_phase(0, 70, 8'hFF, 8'h00);
      // equal sync bytes: two in a row commit a frame
      run_phase(30, 30, 8'hA5, 8'hA5);

      wait_drained();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("sync_length_frame_extractor test passed");
      else
         $display("sync_length_frame_extractor test failed");
      $finish;
   end

endmodule
